### sv/bof_pkg.sv
// ----------------------------------------------------------------------------
// bof_pkg
// Shared types, command codes, size helpers and coordinate saturation for the
// outline flattener.
// ----------------------------------------------------------------------------
package bof_pkg;

  localparam int SEGMENTS_DEF    = 10;
  localparam int COORD_BITS_DEF  = 32;
  localparam int XY_W            = 32;
  localparam int CMD_W           = 2;
  localparam int RCP_SLICE       = 16;

  typedef logic signed [XY_W-1:0] coord_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_QUAD  = 2'd2,
    CMD_CUBIC = 2'd3
  } cmd_code_t;

  localparam logic [1:0] TERM_A = 2'd0;
  localparam logic [1:0] TERM_B = 2'd1;
  localparam logic [1:0] TERM_C = 2'd2;
  localparam logic [1:0] TERM_E = 2'd3;

  typedef struct packed {
    logic       load;
    logic       wgt;
    logic       mac;
    logic       dld;
    logic       div;
    logic       emit;
    logic       last;
    logic [1:0] term;
  } ctl_cmd_t;

  function automatic int wgt_bits(input int seg);
    return $clog2(seg * seg * seg + 1) + 1;
  endfunction

  function automatic int acc_bits(input int seg);
    return XY_W + wgt_bits(seg) + 2;
  endfunction

  function automatic int rcp_log(input int seg);
    return $clog2(2 * seg * seg * seg);
  endfunction

  function automatic int mag_bits(input int seg);
    return XY_W + 1 + rcp_log(seg);
  endfunction

  function automatic int rcp_shift(input int seg);
    return mag_bits(seg) + rcp_log(seg);
  endfunction

  function automatic int rcp_cycles(input int seg);
    return (rcp_shift(seg) + RCP_SLICE - 1) / RCP_SLICE;
  endfunction

  function automatic coord_t sat_coord(input coord_t v, input int bits);
    coord_t hi;
    coord_t lo;
    coord_t r;
    r = v;
    if (bits < XY_W) begin
      hi = 32'sh7FFF_FFFF >>> (XY_W - bits);
      lo = ~hi;
      if (v > hi) begin
        r = hi;
      end else if (v < lo) begin
        r = lo;
      end
    end
    return r;
  endfunction

endpackage

### sv/bof_cmd_if.sv
// ----------------------------------------------------------------------------
// bof_cmd_if
// Valid/ready channel carrying one outline command word.
// ----------------------------------------------------------------------------
interface bof_cmd_if import bof_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  coord_t           ctrl1_x;
  coord_t           ctrl1_y;
  coord_t           ctrl2_x;
  coord_t           ctrl2_y;
  coord_t           end_x;
  coord_t           end_y;

  modport source (
    output valid, cmd, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, cmd, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
    output ready
  );

endinterface

### sv/bof_pt_if.sv
// ----------------------------------------------------------------------------
// bof_pt_if
// Valid/ready channel carrying one flattened outline point word.
// ----------------------------------------------------------------------------
interface bof_pt_if import bof_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   contour_start;
  logic   last;

  modport source (
    output valid, point_x, point_y, contour_start, last,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, contour_start, last,
    output ready
  );

endinterface

### sv/bezier_outline_flattener.sv
// ----------------------------------------------------------------------------
// bezier_outline_flattener
// Flattens glyph outline commands in 26.6 fixed point into outline points,
// evaluating curves at uniform parameter steps with exact rounding.
// ----------------------------------------------------------------------------
//   channel  dir  handshake    word
//   cmds     in   valid/ready  cmd, ctrl1_x/y, ctrl2_x/y, end_x/y
//   points   out  valid/ready  point_x/y, contour_start, last
//
// A move or line is accepted, then handed off to the output register. Each
// curve point steps through the weight load, the four weighted terms, the
// divider load and the divider iterations, then the handoff; the exact
// division retires one 16-bit reciprocal slice per cycle, and a curve yields
// SEGMENTS + 1 points.
// A full output register holds the sequencer until the sink takes it.
// A new command is taken while the final point still waits in the output register.
// Synchronous reset clears the sequencer, the output valid and the pen to 0,0.
// ----------------------------------------------------------------------------
module bezier_outline_flattener import bof_pkg::*; #(
  parameter int SEGMENTS   = SEGMENTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  bof_cmd_if.sink  cmds,
  bof_pt_if.source points
);

  localparam int KW = $clog2(SEGMENTS + 1);

  ctl_cmd_t      ctl;
  logic [KW-1:0] k;
  logic          out_free;

  bof_ctrl #(
    .SEGMENTS (SEGMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmds.valid),
    .in_cmd   (cmds.cmd),
    .in_ready (cmds.ready),
    .out_free (out_free),
    .ctl      (ctl),
    .k        (k)
  );

  bof_datapath #(
    .SEGMENTS   (SEGMENTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .k        (k),
    .cmd      (cmds.cmd),
    .ctrl1_x  (cmds.ctrl1_x),
    .ctrl1_y  (cmds.ctrl1_y),
    .ctrl2_x  (cmds.ctrl2_x),
    .ctrl2_y  (cmds.ctrl2_y),
    .end_x    (cmds.end_x),
    .end_y    (cmds.end_y),
    .out_free (out_free),
    .points   (points)
  );

endmodule

### sv/bof_ctrl.sv
// ----------------------------------------------------------------------------
// bof_ctrl
// Sequencer for the flattener: steps the curve parameter, the four weighted
// terms, the divider iterations and the point handoff.
// ----------------------------------------------------------------------------
module bof_ctrl import bof_pkg::*; #(
  parameter int SEGMENTS = SEGMENTS_DEF,
  localparam int KW      = $clog2(SEGMENTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  logic             out_free,
  output ctl_cmd_t         ctl,
  output logic [KW-1:0]    k
);

  localparam int DC = rcp_cycles(SEGMENTS);
  localparam int CW = $clog2(DC);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WGT  = 6'b000010,
    ST_MAC  = 6'b000100,
    ST_DLD  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [KW-1:0] k_next;
  logic [1:0]    term, term_next;
  logic [CW-1:0] dcnt, dcnt_next;
  logic          curve, curve_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      term  <= TERM_A;
      dcnt  <= '0;
      curve <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      term  <= term_next;
      dcnt  <= dcnt_next;
      curve <= curve_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    term_next  = term;
    dcnt_next  = dcnt;
    curve_next = curve;
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.term   = term;
    ctl.last   = !curve || (k == KW'(SEGMENTS));
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          k_next     = '0;
          curve_next = (in_cmd == CMD_QUAD) || (in_cmd == CMD_CUBIC);
          state_next = curve_next ? ST_WGT : ST_FIN;
        end
      end
      ST_WGT: begin
        ctl.wgt    = 1'b1;
        term_next  = TERM_A;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        ctl.mac   = 1'b1;
        term_next = term + 2'd1;
        if (term == TERM_E) begin
          state_next = ST_DLD;
        end
      end
      ST_DLD: begin
        ctl.dld    = 1'b1;
        dcnt_next  = CW'(DC - 1);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctl.div   = 1'b1;
        dcnt_next = dcnt - 1'b1;
        if (dcnt == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ctl.emit = 1'b1;
          if (ctl.last) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + 1'b1;
            state_next = ST_WGT;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/bof_datapath.sv
// ----------------------------------------------------------------------------
// bof_datapath
// Operand and pen registers, Bernstein weights, one multiply-accumulate unit
// per axis, a reciprocal multiply divider per axis that retires one 16-bit
// reciprocal slice per cycle, and the output word register.
// ----------------------------------------------------------------------------
module bof_datapath import bof_pkg::*; #(
  parameter int SEGMENTS   = SEGMENTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int KW        = $clog2(SEGMENTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         ctl,
  input  logic [KW-1:0]    k,
  input  logic [CMD_W-1:0] cmd,
  input  coord_t           ctrl1_x,
  input  coord_t           ctrl1_y,
  input  coord_t           ctrl2_x,
  input  coord_t           ctrl2_y,
  input  coord_t           end_x,
  input  coord_t           end_y,
  output logic             out_free,
  bof_pt_if.source         points
);

  localparam int WB   = wgt_bits(SEGMENTS);
  localparam int AW   = acc_bits(SEGMENTS);
  localparam int NW   = mag_bits(SEGMENTS);
  localparam int SH   = rcp_shift(SEGMENTS);
  localparam int RP   = rcp_cycles(SEGMENTS) * RCP_SLICE;
  localparam int PW   = NW + RP;
  localparam int DEN2 = SEGMENTS * SEGMENTS;
  localparam int DEN3 = DEN2 * SEGMENTS;

  // The sum is biased by 2^32 denominators so the numerator stays positive;
  // the bias drops out of the low 32 quotient bits.
  localparam logic [PW-1:0] SCALE     = PW'(1) << SH;
  localparam logic [PW-1:0] RCP2_FULL = (SCALE + PW'(2 * DEN2 - 1)) / PW'(2 * DEN2);
  localparam logic [PW-1:0] RCP3_FULL = (SCALE + PW'(2 * DEN3 - 1)) / PW'(2 * DEN3);
  localparam logic [RP-1:0] RCP2      = RCP2_FULL[RP-1:0];
  localparam logic [RP-1:0] RCP3      = RCP3_FULL[RP-1:0];

  logic [CMD_W-1:0]     cmd_r;
  coord_t               pen_x, pen_y;
  coord_t               a_x, a_y, b_x, b_y, c_x, c_y, e_x, e_y;
  logic [WB-1:0]        w_r [4];
  logic signed [AW-1:0] acc_x, acc_y;
  logic [NW-1:0]        mq_x, mq_y;
  logic [RP-1:0]        rsh;
  logic [PW-1:0]        pr_x, pr_y;

  logic                    is_curve, is_cubic;
  logic [WB-1:0]           kk, uu, k2, u2, ku;
  logic [WB-1:0]           w0, w1, w2, w3;
  logic [WB-1:0]           den;
  coord_t                  sel_x, sel_y;
  logic [WB-1:0]           w_sel;
  logic signed [WB+XY_W:0] prod_x, prod_y;
  logic [NW-1:0]           mag_x, mag_y;
  logic [RP-1:0]           rcp;
  logic [RCP_SLICE-1:0]    slice;
  logic [NW+RCP_SLICE-1:0] pp_x, pp_y;
  coord_t                  q_x, q_y;
  coord_t                  pt_x, pt_y;

  assign is_curve = (cmd_r == CMD_QUAD) || (cmd_r == CMD_CUBIC);
  assign is_cubic = (cmd_r == CMD_CUBIC);

  always_comb begin
    kk = WB'(k);
    uu = WB'(SEGMENTS) - WB'(k);
    k2 = kk * kk;
    u2 = uu * uu;
    ku = kk * uu;
    if (is_cubic) begin
      w0  = u2 * uu;
      w1  = WB'(3) * ku * uu;
      w2  = WB'(3) * ku * kk;
      w3  = k2 * kk;
      den = WB'(DEN3);
    end else begin
      w0  = u2;
      w1  = WB'(2) * ku;
      w2  = '0;
      w3  = k2;
      den = WB'(DEN2);
    end
  end

  always_comb begin
    case (ctl.term)
      TERM_A:  begin sel_x = a_x; sel_y = a_y; end
      TERM_B:  begin sel_x = b_x; sel_y = b_y; end
      TERM_C:  begin sel_x = c_x; sel_y = c_y; end
      TERM_E:  begin sel_x = e_x; sel_y = e_y; end
      default: begin sel_x = e_x; sel_y = e_y; end
    endcase
    w_sel  = w_r[ctl.term];
    prod_x = $signed({1'b0, w_sel}) * sel_x;
    prod_y = $signed({1'b0, w_sel}) * sel_y;
  end

  always_comb begin
    mag_x = (NW'(acc_x) << 1) + NW'(den) + (NW'(den) << (XY_W + 1));
    mag_y = (NW'(acc_y) << 1) + NW'(den) + (NW'(den) << (XY_W + 1));
    rcp   = is_cubic ? RCP3 : RCP2;
    slice = rsh[RP-1 -: RCP_SLICE];
    pp_x  = mq_x * slice;
    pp_y  = mq_y * slice;
  end

  always_comb begin
    q_x  = pr_x[SH +: XY_W];
    q_y  = pr_y[SH +: XY_W];
    pt_x = is_curve ? sat_coord(q_x, COORD_BITS) : pen_x;
    pt_y = is_curve ? sat_coord(q_y, COORD_BITS) : pen_y;
  end

  assign out_free = !points.valid || points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      points.valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        pen_x <= sat_coord(end_x, COORD_BITS);
        pen_y <= sat_coord(end_y, COORD_BITS);
      end
      if (ctl.emit) begin
        points.valid <= 1'b1;
      end else if (points.ready) begin
        points.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd;
      a_x   <= pen_x;
      a_y   <= pen_y;
      b_x   <= ctrl1_x;
      b_y   <= ctrl1_y;
      c_x   <= ctrl2_x;
      c_y   <= ctrl2_y;
      e_x   <= end_x;
      e_y   <= end_y;
    end
    if (ctl.wgt) begin
      w_r[0] <= w0;
      w_r[1] <= w1;
      w_r[2] <= w2;
      w_r[3] <= w3;
      acc_x  <= '0;
      acc_y  <= '0;
    end
    if (ctl.mac) begin
      acc_x <= acc_x + AW'(prod_x);
      acc_y <= acc_y + AW'(prod_y);
    end
    if (ctl.dld) begin
      mq_x <= mag_x;
      mq_y <= mag_y;
      rsh  <= rcp;
      pr_x <= '0;
      pr_y <= '0;
    end
    if (ctl.div) begin
      pr_x <= (pr_x << RCP_SLICE) + PW'(pp_x);
      pr_y <= (pr_y << RCP_SLICE) + PW'(pp_y);
      rsh  <= rsh << RCP_SLICE;
    end
    if (ctl.emit) begin
      points.point_x       <= pt_x;
      points.point_y       <= pt_y;
      points.contour_start <= (cmd_r == CMD_MOVE);
      points.last          <= ctl.last;
    end
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the outline flattener. Outline commands go in as
// words on the command channel. Each accepted word is flattened by a local
// model of the pen and the Bernstein curve points, and each point word that
// comes out is checked field by field against the oldest outstanding point.
// Both channels idle and stall at random. The point sink holds off once for
// a long stretch, and the command source drains the block three times.
// ----------------------------------------------------------------------------
module testbench import bof_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SEG        = SEGMENTS_DEF;
  localparam int     IDLE_PCT   = 24;
  localparam int     STALL_LEN  = 400;
  localparam int     STALL_AT   = 300;
  localparam int     HANG_LIMIT = 4000;
  localparam int     RANDOM_CNT = 345;

  typedef struct {
    cmd_code_t op;
    coord_t    c1x;
    coord_t    c1y;
    coord_t    c2x;
    coord_t    c2y;
    coord_t    ex;
    coord_t    ey;
  } cmd_word_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   start;
    logic   last;
  } point_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bof_cmd_if cmds ();
  bof_pt_if  points ();

  bezier_outline_flattener u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmds   (cmds),
    .points (points)
  );

  always #6 clk = ~clk;

  cmd_word_t   pending_cmds[$];
  point_word_t expected_points[$];
  cmd_word_t   next_word;
  longint      pen_x = 0;
  longint      pen_y = 0;
  int          errors = 0;
  int          cmds_taken = 0;
  int          points_seen = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  logic        stall_done = 1'b0;
  logic        cmd_fire = 1'b0;
  logic        burst;

  assign burst = (cmds_taken >= 200) && (cmds_taken < 260);

  function automatic longint round_div(input longint num, input longint den);
    longint n2;
    longint d2;
    longint q;
    n2 = 2 * num + den;
    d2 = 2 * den;
    q  = n2 / d2;
    if ((n2 % d2) != 0 && n2 < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic void flatten_word(input cmd_word_t w);
    longint      ax;
    longint      ay;
    longint      bx;
    longint      by;
    longint      cx;
    longint      cy;
    longint      ex;
    longint      ey;
    longint      k;
    longint      u;
    longint      den;
    longint      sx;
    longint      sy;
    point_word_t p;
    ax = pen_x;
    ay = pen_y;
    bx = longint'(w.c1x);
    by = longint'(w.c1y);
    cx = longint'(w.c2x);
    cy = longint'(w.c2y);
    ex = longint'(w.ex);
    ey = longint'(w.ey);
    if (w.op == CMD_MOVE || w.op == CMD_LINE) begin
      p.x     = w.ex;
      p.y     = w.ey;
      p.start = (w.op == CMD_MOVE);
      p.last  = 1'b1;
      expected_points.push_back(p);
    end else begin
      for (k = 0; k <= SEG; k++) begin
        u = SEG - k;
        if (w.op == CMD_QUAD) begin
          den = SEG * SEG;
          sx  = u * u * ax + 2 * k * u * bx + k * k * ex;
          sy  = u * u * ay + 2 * k * u * by + k * k * ey;
        end else begin
          den = SEG * SEG * SEG;
          sx  = u * u * u * ax + 3 * k * u * u * bx + 3 * k * k * u * cx + k * k * k * ex;
          sy  = u * u * u * ay + 3 * k * u * u * by + 3 * k * k * u * cy + k * k * k * ey;
        end
        p.x     = coord_t'(round_div(sx, den));
        p.y     = coord_t'(round_div(sy, den));
        p.start = 1'b0;
        p.last  = (k == SEG);
        expected_points.push_back(p);
      end
    end
    pen_x = ex;
    pen_y = ey;
  endfunction

  function automatic cmd_word_t make_word(input cmd_code_t op, input coord_t c1x,
                                          input coord_t c1y, input coord_t c2x,
                                          input coord_t c2y, input coord_t ex,
                                          input coord_t ey);
    cmd_word_t w;
    w.op  = op;
    w.c1x = c1x;
    w.c1y = c1y;
    w.c2x = c2x;
    w.c2y = c2y;
    w.ex  = ex;
    w.ey  = ey;
    return w;
  endfunction

  function automatic coord_t random_coord();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0, 1: begin
        return coord_t'($urandom);
      end
      2: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: begin
        return coord_t'(int'($urandom_range(131072)) - 65536);
      end
    endcase
  endfunction

  function automatic cmd_word_t random_word();
    int        pick;
    cmd_code_t op;
    pick = $urandom_range(99);
    if (pick < 15) begin
      op = CMD_MOVE;
    end else if (pick < 40) begin
      op = CMD_LINE;
    end else if (pick < 70) begin
      op = CMD_QUAD;
    end else begin
      op = CMD_CUBIC;
    end
    return make_word(op, random_coord(), random_coord(), random_coord(),
                     random_coord(), random_coord(), random_coord());
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmds.valid || expected_points.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      cmds.valid <= 1'b0;
    end else if (cmds.valid && !cmd_fire) begin
    end else if (pending_cmds.size() != 0 && (burst || $urandom_range(99) >= IDLE_PCT)) begin
      next_word = pending_cmds.pop_front();
      cmds.valid   <= 1'b1;
      cmds.cmd     <= next_word.op;
      cmds.ctrl1_x <= next_word.c1x;
      cmds.ctrl1_y <= next_word.c1y;
      cmds.ctrl2_x <= next_word.c2x;
      cmds.ctrl2_y <= next_word.c2y;
      cmds.end_x   <= next_word.ex;
      cmds.end_y   <= next_word.ey;
    end else begin
      cmds.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      points.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      points.ready <= 1'b0;
    end else if (!stall_done && points_seen >= STALL_AT) begin
      stall_done   <= 1'b1;
      stall_left   <= STALL_LEN;
      points.ready <= 1'b0;
    end else begin
      points.ready <= burst || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    point_word_t want;
    cmd_word_t   taken;
    if (rst) begin
      cmd_fire <= 1'b0;
    end else begin
      cmd_fire <= cmds.valid && cmds.ready;
      if (points.valid && points.ready) begin
        points_seen = points_seen + 1;
        if (expected_points.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("unexpected point word x=%0d y=%0d start=%0b last=%0b",
                     points.point_x, points.point_y, points.contour_start, points.last);
          end
        end else begin
          want = expected_points.pop_front();
          if (points.point_x !== want.x || points.point_y !== want.y ||
              points.contour_start !== want.start || points.last !== want.last) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("point %0d mismatch: expected x=%0d y=%0d start=%0b last=%0b, got x=%0d y=%0d start=%0b last=%0b",
                       points_seen, want.x, want.y, want.start, want.last,
                       points.point_x, points.point_y, points.contour_start,
                       points.last);
            end
          end
        end
      end
      if (cmds.valid && cmds.ready) begin
        cmds_taken = cmds_taken + 1;
        taken = make_word(cmd_code_t'(cmds.cmd), cmds.ctrl1_x, cmds.ctrl1_y,
                          cmds.ctrl2_x, cmds.ctrl2_y, cmds.end_x, cmds.end_y);
        flatten_word(taken);
      end
      if ((cmds.valid && cmds.ready) || (points.valid && points.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    coord_t pmax;
    coord_t pmin;
    pmax = 32'sh7FFF_FFFF;
    pmin = 32'sh8000_0000;
    cmds.valid   = 1'b0;
    cmds.cmd     = CMD_MOVE;
    cmds.ctrl1_x = '0;
    cmds.ctrl1_y = '0;
    cmds.ctrl2_x = '0;
    cmds.ctrl2_y = '0;
    cmds.end_x   = '0;
    cmds.end_y   = '0;
    points.ready = 1'b0;

    pending_cmds.push_back(make_word(CMD_QUAD, 640, -320, random_coord(), random_coord(),
                                     1280, 64));
    pending_cmds.push_back(make_word(CMD_MOVE, random_coord(), random_coord(),
                                     random_coord(), random_coord(), 100, 200));
    pending_cmds.push_back(make_word(CMD_LINE, random_coord(), random_coord(),
                                     random_coord(), random_coord(), -300, 50));
    pending_cmds.push_back(make_word(CMD_CUBIC, 1000, 5000, -4000, 3000, 2500, -777));
    pending_cmds.push_back(make_word(CMD_MOVE, pmin, pmax, pmin, pmax, pmax, pmax));
    pending_cmds.push_back(make_word(CMD_LINE, -1, -1, -1, -1, pmin, pmin));
    pending_cmds.push_back(make_word(CMD_QUAD, pmax, pmax, pmin, pmin, pmax, pmax));
    pending_cmds.push_back(make_word(CMD_CUBIC, pmin, pmin, pmax, pmax, pmin, pmin));
    pending_cmds.push_back(make_word(CMD_CUBIC, pmax, pmin, pmin, pmax, pmax, pmin));
    pending_cmds.push_back(make_word(CMD_MOVE, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_word(CMD_QUAD, 0, 0, pmax, pmin, 2, -2));
    pending_cmds.push_back(make_word(CMD_MOVE, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_word(CMD_CUBIC, 0, 0, 0, 0, 4, -4));
    pending_cmds.push_back(make_word(CMD_MOVE, 1, 1, 1, 1, -1, -1));
    pending_cmds.push_back(make_word(CMD_CUBIC, 3, -3, -5, 5, 7, -7));
    pending_cmds.push_back(make_word(CMD_LINE, pmax, pmin, pmax, pmin, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait_drained();

    for (int i = 0; i < RANDOM_CNT; i++) begin
      if (i == 180) begin
        wait_drained();
      end
      pending_cmds.push_back(random_word());
      if (pending_cmds.size() > 40) begin
        while (pending_cmds.size() > 8) begin
          @(negedge clk);
        end
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (expected_points.size() != 0) begin
      errors = errors + expected_points.size();
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/bof_pkg.sv
sv/bof_cmd_if.sv
sv/bof_pt_if.sv
sv/bof_ctrl.sv
sv/bof_datapath.sv
sv/bezier_outline_flattener.sv
test/testbench.sv
